// File: hw/rtl/jsp_pkg.sv
// shared types and codes for the jpeg scan header parser
// used by jsp_parse and jpeg_scan_header_parser_top; no dependencies
package jsp_pkg;

	localparam int unsigned CountW    = 3;
	localparam int unsigned SlotW     = 8;
	localparam int unsigned TableW    = 4;
	localparam int unsigned StatusW   = 3;
	localparam int unsigned OutDataW  = 24;
	localparam int unsigned CfgIndexW = 1;

	// result kinds carried on tuser
	localparam logic KIND_COMP   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// configuration register indexes
	localparam logic [CfgIndexW-1:0] CFG_COMPONENT_COUNT = 1'b0;
	localparam logic [CfgIndexW-1:0] CFG_GREYSCALE_MODE  = 1'b1;

	localparam logic [7:0] SPECTRAL_END = 8'd63;
	localparam logic [7:0] MAX_COLOR_ID = 8'd3;
	localparam logic [15:0] LEN_BASE    = 16'd6;

	typedef enum logic [StatusW-1:0] {
		ST_OK         = 3'd0,
		ST_BAD_COUNT  = 3'd1,
		ST_BAD_ID     = 3'd2,
		ST_BAD_SPEC   = 3'd3,
		ST_BAD_APPROX = 3'd4,
		ST_BAD_LENGTH = 3'd5
	} status_t;

	typedef struct packed {
		logic [CountW-1:0] component_count;
		logic              greyscale_mode;
	} cfg_t;

	typedef struct packed {
		logic              kind;
		logic [SlotW-1:0]  comp_slot;
		logic [TableW-1:0] dc_table;
		logic [TableW-1:0] ac_table;
		status_t           status;
		logic              last;
	} res_t;

endpackage

// File: hw/rtl/jsp_parse.sv
// byte-phase parser for a start-of-scan segment: state plus one-byte decode
// depends on jsp_pkg
module jsp_parse import jsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] seg_byte,
	input  logic       seg_first,
	input  cfg_t       cfg,
	output logic       res_valid,
	output res_t       res
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_LEN_LO, PH_COUNT, PH_ID, PH_SEL, PH_SS, PH_SE, PH_APPROX
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [15:0]       seg_length_q, seg_length_d;
	logic [CountW-1:0] comp_total_q, comp_total_d;
	logic [CountW-1:0] comps_done_q, comps_done_d;
	logic [CountW-1:0] done_inc;
	logic [SlotW-1:0]  pending_slot_q, pending_slot_d;
	logic              spectral_bad_q, spectral_bad_d;
	logic              grey_seen_q, grey_seen_d;
	logic [15:0]       expected_len;

	assign done_inc     = comps_done_q + 1'b1;
	assign expected_len = LEN_BASE + {12'd0, comp_total_q, 1'b0};

	always_comb begin
		phase_d        = phase_q;
		seg_length_d   = seg_length_q;
		comp_total_d   = comp_total_q;
		comps_done_d   = comps_done_q;
		pending_slot_d = pending_slot_q;
		spectral_bad_d = spectral_bad_q;
		grey_seen_d    = grey_seen_q;
		res_valid      = 1'b0;
		res            = '0;
		res.status     = ST_OK;
		if (seg_first) begin
			seg_length_d   = {seg_byte, 8'h00};
			comp_total_d   = '0;
			comps_done_d   = '0;
			pending_slot_d = '0;
			spectral_bad_d = 1'b0;
			phase_d        = PH_LEN_LO;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_LEN_LO: begin
					seg_length_d[7:0] = seg_byte;
					phase_d           = PH_COUNT;
				end
				PH_COUNT: begin
					if (seg_byte == 8'd0 || seg_byte != {5'd0, cfg.component_count}) begin
						res_valid  = 1'b1;
						res.kind   = KIND_STATUS;
						res.status = ST_BAD_COUNT;
						res.last   = 1'b1;
						phase_d    = PH_IDLE;
					end else begin
						comp_total_d = seg_byte[CountW-1:0];
						comps_done_d = '0;
						phase_d      = PH_ID;
					end
				end
				PH_ID: begin
					priority if (seg_byte == 8'd0 || cfg.greyscale_mode || grey_seen_q) begin
						grey_seen_d    = 1'b1;
						pending_slot_d = seg_byte;
						phase_d        = PH_SEL;
					end else if (seg_byte <= MAX_COLOR_ID) begin
						pending_slot_d = seg_byte - 8'd1;
						phase_d        = PH_SEL;
					end else begin
						res_valid  = 1'b1;
						res.kind   = KIND_STATUS;
						res.status = ST_BAD_ID;
						res.last   = 1'b1;
						phase_d    = PH_IDLE;
					end
				end
				PH_SEL: begin
					res_valid     = 1'b1;
					res.kind      = KIND_COMP;
					res.comp_slot = pending_slot_q;
					res.dc_table  = seg_byte[7:4];
					res.ac_table  = seg_byte[3:0];
					comps_done_d  = done_inc;
					phase_d       = (done_inc == comp_total_q) ? PH_SS : PH_ID;
				end
				PH_SS: begin
					spectral_bad_d = (seg_byte != 8'd0);
					phase_d        = PH_SE;
				end
				PH_SE: begin
					if (seg_byte != SPECTRAL_END)
						spectral_bad_d = 1'b1;
					phase_d = PH_APPROX;
				end
				PH_APPROX: begin
					res_valid = 1'b1;
					res.kind  = KIND_STATUS;
					res.last  = 1'b1;
					phase_d   = PH_IDLE;
					priority if (spectral_bad_q)
						res.status = ST_BAD_SPEC;
					else if (seg_byte != 8'd0)
						res.status = ST_BAD_APPROX;
					else if (seg_length_q != expected_len)
						res.status = ST_BAD_LENGTH;
					else
						res.status = ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			seg_length_q   <= '0;
			comp_total_q   <= '0;
			comps_done_q   <= '0;
			pending_slot_q <= '0;
			spectral_bad_q <= 1'b0;
			grey_seen_q    <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			seg_length_q   <= seg_length_d;
			comp_total_q   <= comp_total_d;
			comps_done_q   <= comps_done_d;
			pending_slot_q <= pending_slot_d;
			spectral_bad_q <= spectral_bad_d;
			grey_seen_q    <= grey_seen_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_status_ends_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_valid && res.kind == KIND_STATUS) |=> (phase_q == PH_IDLE))
		else $error("segment status did not return the parser to idle");
	a_first_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && seg_first) |=> (phase_q == PH_LEN_LO))
		else $error("first byte did not restart the parser");
	a_grey_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		grey_seen_q |=> grey_seen_q)
		else $error("greyscale flag cleared without reset");
	a_done_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ID || phase_q == PH_SEL) |-> (comps_done_q < comp_total_q))
		else $error("component counter ran past the count");
`endif

endmodule

// File: hw/rtl/jpeg_scan_header_parser_top.sv
// the result of an accepted byte is registered into the main entry (shown on m_tvalid), or into skid if main is held
// throughput: one byte per cycle while the skid entry is empty; the parser decodes each byte in the accept cycle
// a two-entry output stage (main plus skid) keeps s_tready high while a result waits
// arst_n clears the parser to idle, empties the output stage, and loads
// component_count = 1 and greyscale_mode = 0
// top level: configuration registers, jsp_parse and the output stage; depends on jsp_pkg
module jpeg_scan_header_parser_top import jsp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // seg_byte
	input  logic                 s_tuser,   // seg_first
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OutDataW-1:0]  m_tdata,   // comp_slot, dc_table, ac_table, status, zero pad
	output logic                 m_tuser,   // result_kind
	output logic                 m_tlast,   // last
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [CountW-1:0]    cfg_data
);

	cfg_t cfg_q;
	logic accept;
	logic res_valid;
	res_t res;
	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.component_count <= CountW'(1);
			cfg_q.greyscale_mode  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COMPONENT_COUNT: cfg_q.component_count <= cfg_data;
				CFG_GREYSCALE_MODE:  cfg_q.greyscale_mode  <= cfg_data[0];
			endcase
		end
	end

	assign s_tready = !skid_v_q;
	assign accept   = s_tvalid && s_tready;

	jsp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.seg_byte  (s_tdata),
		.seg_first (s_tuser),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	assign push = accept && res_valid;
	assign pop  = main_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			main_q   <= '0;
			skid_q   <= '0;
		end else begin
			if (skid_v_q) begin
				// no push possible while the skid entry is full
				if (pop) begin
					main_q   <= skid_q;
					skid_v_q <= 1'b0;
				end
			end else if (push) begin
				if (!main_v_q || pop) begin
					main_q   <= res;
					main_v_q <= 1'b1;
				end else begin
					skid_q   <= res;
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				main_v_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = main_v_q;
	assign m_tuser  = main_q.kind;
	assign m_tlast  = main_q.last;
	assign m_tdata  = {5'd0, main_q.status, main_q.ac_table, main_q.dc_table, main_q.comp_slot};

`ifndef NO_ASSERTIONS
	a_skid_needs_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry full while main entry empty");
	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_STATUS))
		else $error("last flag on a component result");
	a_comp_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_COMP) |-> (m_tdata[18:16] == 3'd0 && !m_tlast))
		else $error("component result carries a status");
	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && m_tready) |=> !skid_v_q)
		else $error("skid entry not drained on a taken result");
`endif

endmodule

// File: tb/jpeg_scan_header_parser_top_test.sv
// self-checking testbench for the jpeg scan header parser top level
// depends on jsp_pkg and jpeg_scan_header_parser_top; drives directed and random scan headers
module jpeg_scan_header_parser_top_test;
	import jsp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT    = 4000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int HOLD_CYCLES    = 300;
	localparam int BYTES_PER_PLAN = 55;
	localparam int NUM_PLANS      = 9;
	localparam int NUM_DIRECTED   = 25;

	// one register setting per random phase: {greyscale_mode, component_count}
	localparam logic [3:0] CFG_PLAN [NUM_PLANS] = '{
		4'b0_001, 4'b0_010, 4'b0_011, 4'b0_100, 4'b0_000,
		4'b1_010, 4'b0_100, 4'b1_001, 4'b0_011
	};
	// from this phase on, id 0 and greyscale mode may latch raw-id mapping for good
	localparam int FIRST_RAW_PLAN = 5;

	typedef enum logic [3:0] {
		HDR_IDLE, HDR_LEN_LO, HDR_COUNT, HDR_ID, HDR_SEL, HDR_SS, HDR_SE, HDR_APPROX
	} hdr_phase_t;

	typedef struct {
		logic [7:0] seg_byte;
		logic       seg_first;
		bit         pinned;
		res_t       want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OutDataW-1:0]  m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_we;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CountW-1:0]    cfg_data;

	// parser shadow state
	hdr_phase_t        hdr_phase;
	logic [15:0]       hdr_length;
	logic [7:0]        hdr_comp_total;
	logic [2:0]        hdr_comps_done;
	logic [7:0]        hdr_slot;
	logic              hdr_spec_bad;
	logic              hdr_raw_ids;
	logic [CountW-1:0] cfg_count;
	logic              cfg_grey;

	res_t        scan_results_due[$];
	stim_row_t   dir_rows[NUM_DIRECTED];
	int          fail_count = 0;
	int          bytes_sent = 0;
	int unsigned comp_seen = 0;
	int unsigned status_seen = 0;
	int          quiet_cycles = 0;
	bit          steady = 1'b0;
	bit          hold_off_req = 1'b0;

	jpeg_scan_header_parser_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic res_t status_result(input status_t code);
		res_t r;
		r = '0;
		r.kind = KIND_STATUS;
		r.status = code;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic res_t comp_result(input logic [7:0] slot, input logic [7:0] sel);
		res_t r;
		r = '0;
		r.kind = KIND_COMP;
		r.comp_slot = slot;
		r.dc_table = sel[7:4];
		r.ac_table = sel[3:0];
		r.status = ST_OK;
		return r;
	endfunction

	function automatic res_t close_segment(input status_t code);
		hdr_phase = HDR_IDLE;
		return status_result(code);
	endfunction

	// works out what one header byte produces; returns 1 when a result is due
	function automatic bit decode_scan_byte(input logic [7:0] b, input logic first,
			output res_t r);
		r = '0;
		if (first) begin
			hdr_length = {b, 8'h00};
			hdr_comp_total = '0;
			hdr_comps_done = '0;
			hdr_slot = '0;
			hdr_spec_bad = 1'b0;
			hdr_phase = HDR_LEN_LO;
			return 1'b0;
		end
		case (hdr_phase)
			HDR_LEN_LO: begin
				hdr_length[7:0] = b;
				hdr_phase = HDR_COUNT;
				return 1'b0;
			end
			HDR_COUNT: begin
				if (b == 8'd0 || b != 8'(cfg_count)) begin
					r = close_segment(ST_BAD_COUNT);
					return 1'b1;
				end
				hdr_comp_total = b;
				hdr_comps_done = '0;
				hdr_phase = HDR_ID;
				return 1'b0;
			end
			HDR_ID: begin
				if (b == 8'd0 || cfg_grey || hdr_raw_ids) begin
					hdr_raw_ids = 1'b1;
					hdr_slot = b;
				end else if (b <= MAX_COLOR_ID) begin
					hdr_slot = b - 8'd1;
				end else begin
					r = close_segment(ST_BAD_ID);
					return 1'b1;
				end
				hdr_phase = HDR_SEL;
				return 1'b0;
			end
			HDR_SEL: begin
				r = comp_result(hdr_slot, b);
				hdr_comps_done = hdr_comps_done + 3'd1;
				hdr_phase = (8'(hdr_comps_done) == hdr_comp_total) ? HDR_SS : HDR_ID;
				return 1'b1;
			end
			HDR_SS: begin
				hdr_spec_bad = (b != 8'd0);
				hdr_phase = HDR_SE;
				return 1'b0;
			end
			HDR_SE: begin
				if (b != SPECTRAL_END)
					hdr_spec_bad = 1'b1;
				hdr_phase = HDR_APPROX;
				return 1'b0;
			end
			HDR_APPROX: begin
				if (hdr_spec_bad)
					r = close_segment(ST_BAD_SPEC);
				else if (b != 8'd0)
					r = close_segment(ST_BAD_APPROX);
				else if (hdr_length != LEN_BASE + 16'(hdr_comp_total) * 16'd2)
					r = close_segment(ST_BAD_LENGTH);
				else
					r = close_segment(ST_OK);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] mostly(input logic [7:0] usual);
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom_range(0, 255));
		return usual;
	endfunction

	function automatic logic [7:0] pick_id(input bit zero_ok);
		if ($urandom_range(0, 9) == 0)
			return zero_ok ? 8'($urandom_range(0, 255)) : 8'($urandom_range(4, 255));
		return zero_ok ? 8'($urandom_range(0, 3)) : 8'($urandom_range(1, 3));
	endfunction

	task automatic send_item(input logic [7:0] b, input logic first, input bit pinned,
			input res_t pinned_res);
		int   gap;
		bit   due;
		res_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= first;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
		due = decode_scan_byte(b, first, r);
		if (pinned)
			scan_results_due.push_back(pinned_res);
		else if (due)
			scan_results_due.push_back(r);
	endtask

	// mostly well-formed headers with random tables; some noise, bad fields and cut-offs
	task automatic send_segment(input bit zero_ok);
		logic [7:0]  seg[$];
		logic [15:0] len;
		logic [7:0]  cnt;
		int          n;
		int          keep;
		int          pick;
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3))
				send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
		len = ($urandom_range(0, 4) == 0) ? 16'($urandom()) :
			LEN_BASE + 16'(cfg_count) * 16'd2;
		pick = $urandom_range(0, 13);
		if (pick == 0)
			cnt = 8'($urandom_range(0, 255));
		else if (pick == 1)
			cnt = 8'($urandom_range(0, 7));
		else
			cnt = 8'(cfg_count);
		seg.push_back(len[15:8]);
		seg.push_back(len[7:0]);
		seg.push_back(cnt);
		n = (cnt >= 8'd1 && cnt <= 8'd7) ? int'(cnt) : 1;
		repeat (n) begin
			seg.push_back(pick_id(zero_ok));
			seg.push_back(8'($urandom_range(0, 255)));
		end
		seg.push_back(mostly(8'd0));
		seg.push_back(mostly(SPECTRAL_END));
		seg.push_back(mostly(8'd0));
		keep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, seg.size()) : seg.size();
		for (int i = 0; i < keep; i++)
			send_item(seg[i], i == 0, 1'b0, '0);
	endtask

	task automatic write_settings(input logic [3:0] plan);
		s_tvalid <= 1'b0;
		while (scan_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_COMPONENT_COUNT;
		cfg_data <= plan[2:0];
		@(posedge clk);
		cfg_count = plan[2:0];
		cfg_index <= CFG_GREYSCALE_MODE;
		cfg_data <= {2'b00, plan[3]};
		@(posedge clk);
		cfg_grey = plan[3];
		cfg_we <= 1'b0;
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// receiver side: random stalls, one long hold-off on request
	initial begin
		int run;
		int gap;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				run = $urandom_range(1, 8);
				m_tready <= 1'b1;
				repeat (run) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					m_tready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (scan_results_due.size() == 0) begin
				$error("result item with none expected: tuser %0d tdata %h", m_tuser, m_tdata);
				fail_count++;
			end else begin
				want = scan_results_due.pop_front();
				check_field("result_kind", want.kind, m_tuser);
				check_field("comp_slot", want.comp_slot, m_tdata[7:0]);
				check_field("dc_table", want.dc_table, m_tdata[11:8]);
				check_field("ac_table", want.ac_table, m_tdata[15:12]);
				check_field("status", want.status, m_tdata[18:16]);
				check_field("tdata pad", 0, m_tdata[OutDataW-1:19]);
				check_field("last", want.last, m_tlast);
				if (want.kind == KIND_COMP)
					comp_seen++;
				else
					status_seen++;
			end
		end
	end

	// watchdog: ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("no item moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, scan_results_due.size());
			$display("FAIL jpeg_scan_header_parser_top");
			$finish;
		end
	end

	initial begin
		int plan_start;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hdr_phase = HDR_IDLE;
		hdr_length = '0;
		hdr_comp_total = '0;
		hdr_comps_done = '0;
		hdr_slot = '0;
		hdr_spec_bad = 1'b0;
		hdr_raw_ids = 1'b0;
		cfg_count = 3'd1;
		cfg_grey = 1'b0;

		// runs at the reset setting: one component, color ids
		dir_rows = '{
			// count byte of zero
			'{8'h00, 1'b1, 1'b0, '0},
			'{8'h08, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, status_result(ST_BAD_COUNT)},
			// stray byte while idle
			'{8'hFF, 1'b0, 1'b0, '0},
			// id above the color range
			'{8'h00, 1'b1, 1'b0, '0},
			'{8'h08, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, status_result(ST_BAD_ID)},
			// restart after one length byte, then spectral and approx both bad
			'{8'hFF, 1'b1, 1'b0, '0},
			'{8'h00, 1'b1, 1'b0, '0},
			'{8'h08, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h03, 1'b0, 1'b0, '0},
			'{8'hF0, 1'b0, 1'b1, comp_result(8'd2, 8'hF0)},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h3F, 1'b0, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b1, status_result(ST_BAD_SPEC)},
			// good body, wrong length
			'{8'h00, 1'b1, 1'b0, '0},
			'{8'hFF, 1'b0, 1'b0, '0},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h02, 1'b0, 1'b0, '0},
			'{8'h0F, 1'b0, 1'b1, comp_result(8'd1, 8'h0F)},
			'{8'h00, 1'b0, 1'b0, '0},
			'{8'h3F, 1'b0, 1'b0, '0},
			'{8'h00, 1'b0, 1'b1, status_result(ST_BAD_LENGTH)}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].seg_byte, dir_rows[i].seg_first, dir_rows[i].pinned,
				dir_rows[i].want);

		for (int p = 0; p < NUM_PLANS; p++) begin
			write_settings(CFG_PLAN[p]);
			steady = (p == 3);
			if (p == 1)
				hold_off_req = 1'b1;
			plan_start = bytes_sent;
			while (bytes_sent - plan_start < BYTES_PER_PLAN)
				send_segment(p >= FIRST_RAW_PLAN);
		end
		s_tvalid <= 1'b0;

		while (scan_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d header bytes over %0d register settings", bytes_sent, NUM_PLANS + 1);
		$display("checked %0d table selections and %0d segment statuses", comp_seen,
			status_seen);
		if (fail_count == 0)
			$display("PASS jpeg_scan_header_parser_top");
		else
			$display("FAIL jpeg_scan_header_parser_top");
		$finish;
	end

endmodule
